@@ src/osm_pkg.sv @@
package osm_pkg;

	localparam int OP_W     = 3;
	localparam int ST_W     = 2;
	localparam int ANSWER_W = 31;
	localparam int OPERAND_W = 31;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_RANK   = 3'd2;
	localparam logic [OP_W-1:0] OP_KTH    = 3'd3;
	localparam logic [OP_W-1:0] OP_PRED   = 3'd4;
	localparam logic [OP_W-1:0] OP_SUCC   = 3'd5;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_NONE = 2'd2;

	localparam int TREE_RADIX = 16;

	typedef struct packed {
		logic lt;
		logic ge;
		logic gt;
		logic big;
	} flags_t;

	typedef struct packed {
		logic            exec;
		logic            ins;
		logic            rem;
		logic [OP_W-1:0] op;
	} cmd_t;

	function automatic int level_nodes(input int n, input int lvl);
		int c;
		c = n;
		for (int i = 0; i < lvl; i++) begin
			c = (c + TREE_RADIX - 1) / TREE_RADIX;
		end
		return c;
	endfunction

	function automatic int tree_levels(input int n);
		int c;
		int l;
		c = n;
		l = 0;
		while (c > 1) begin
			c = (c + TREE_RADIX - 1) / TREE_RADIX;
			l++;
		end
		if (l == 0) begin
			l = 1;
		end
		return l;
	endfunction

endpackage

@@ src/order_statistic_multiset.sv @@
// channel  | beat when              | payload
// ---------+------------------------+------------------------------
// in       | in_valid & in_ready    | operation, operand
// out      | out_valid & out_ready  | answer, status, running_xor
//
// each item runs in order through these steps: take the beat, the parallel compare and shift
// in the cell row, the registered radix-16 or-tree that picks the matching cell, and finish;
// a new beat is taken only after the last item has passed its finish step.
// a finished result sits in the output register while the next item runs;
// the finish step waits only if that register is still full.
// reset clears the count, last answer and accumulator; the cells need none.
module order_statistic_multiset #(
	parameter int CAPACITY   = 1024,
	parameter int VALUE_BITS = 31
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [osm_pkg::OP_W-1:0]          operation,
	input  logic [osm_pkg::OPERAND_W-1:0]     operand,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [osm_pkg::ANSWER_W-1:0]      answer,
	output logic [osm_pkg::ST_W-1:0]          status,
	output logic [osm_pkg::ANSWER_W-1:0]      running_xor
);
	import osm_pkg::*;

	localparam int VB          = VALUE_BITS;
	localparam int IW          = $clog2(CAPACITY);
	localparam int CW          = $clog2(CAPACITY + 1);
	localparam int LW          = VB + IW + 1;
	localparam int TREE_LEVELS = tree_levels(CAPACITY);
	localparam int CNT_W       = $clog2(TREE_LEVELS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] wait_q;
	logic [OP_W-1:0]  op_q;
	logic [VB-1:0]    v_q;
	logic [CW-1:0]    count_q;
	logic [VB-1:0]    last_q;
	logic [VB-1:0]    acc_q;
	logic             out_valid_q;
	logic [ANSWER_W-1:0] answer_q;
	logic [ST_W-1:0]     status_q;
	logic [ANSWER_W-1:0] xor_q;

	cmd_t          cmd;
	logic [VB-1:0] cell_value [CAPACITY];
	flags_t        cell_flags [CAPACITY];
	logic [LW-1:0] cell_leaf  [CAPACITY];
	logic [LW-1:0] root;

	logic          full;
	logic          root_hit;
	logic [IW-1:0] root_idx;
	logic [VB-1:0] root_val;
	logic [CW:0]   rank_w;
	logic [VB-1:0] res_answer;
	logic [ST_W-1:0] res_status;
	logic          res_query;
	logic [CW-1:0] count_next;
	logic          fin_go;

	assign full     = count_q == CW'(CAPACITY);
	assign cmd.exec = state_q == S_EXEC;
	assign cmd.ins  = (op_q == OP_INSERT) && !full;
	assign cmd.rem  = op_q == OP_REMOVE;
	assign cmd.op   = op_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VB-1:0] lv;
		logic [VB-1:0] rv;
		flags_t        lf;
		flags_t        rf;
		if (i == 0) begin : g_first
			assign lv = '0;
			assign lf = '0;
		end else begin : g_mid_l
			assign lv = cell_value[i-1];
			assign lf = cell_flags[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv = '0;
			assign rf = '0;
		end else begin : g_mid_r
			assign rv = cell_value[i+1];
			assign rf = cell_flags[i+1];
		end
		osm_cell #(
			.VB  (VB),
			.IW  (IW),
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.v           (v_q),
			.count       (count_q),
			.left_value  (lv),
			.left_flags  (lf),
			.right_value (rv),
			.right_flags (rf),
			.value       (cell_value[i]),
			.flags       (cell_flags[i]),
			.leaf        (cell_leaf[i])
		);
	end

	osm_tree #(
		.N (CAPACITY),
		.W (LW)
	) u_tree (
		.clk  (clk),
		.leaf (cell_leaf),
		.root (root)
	);

	assign root_hit = root[LW-1];
	assign root_idx = root[LW-2 -: IW];
	assign root_val = root[VB-1:0];
	assign rank_w   = root_hit ? ((CW+1)'(root_idx) + (CW+1)'(2)) : (CW+1)'(1);

	always_comb begin
		res_answer = '0;
		res_status = ST_OK;
		res_query  = 1'b0;
		count_next = count_q;
		unique case (op_q)
			OP_INSERT: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					count_next = count_q + CW'(1);
				end
			end
			OP_REMOVE: begin
				if (root_hit) begin
					count_next = count_q - CW'(1);
				end else begin
					res_status = ST_NONE;
				end
			end
			OP_RANK: begin
				res_answer = VB'(rank_w);
				res_query  = 1'b1;
			end
			OP_KTH, OP_PRED, OP_SUCC: begin
				if (root_hit) begin
					res_answer = root_val;
					res_query  = 1'b1;
				end else begin
					res_status = ST_NONE;
				end
			end
			default: res_status = ST_NONE;
		endcase
	end

	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= '0;
			count_q     <= '0;
			last_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					wait_q  <= CNT_W'(TREE_LEVELS - 1);
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (wait_q == '0) begin
						state_q <= S_FIN;
					end else begin
						wait_q <= wait_q - CNT_W'(1);
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q     <= S_IDLE;
						count_q     <= count_next;
						if (res_query) begin
							last_q <= res_answer;
							acc_q  <= acc_q ^ res_answer;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= operation;
			v_q  <= VB'(operand) ^ last_q;
		end
		if (fin_go) begin
			answer_q <= ANSWER_W'(res_answer);
			status_q <= res_status;
			xor_q    <= ANSWER_W'(res_query ? (acc_q ^ res_answer) : acc_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign answer      = answer_q;
	assign status      = status_q;
	assign running_xor = xor_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC)
		else $error("accepted beat did not start the cell row");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result raised outside the finish step");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> answer_q == '0)
		else $error("failed item carries a nonzero answer");

	a_count_fin: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q) == S_FIN)
		else $error("element count moved outside the finish step");

endmodule

@@ src/osm_cell.sv @@
module osm_cell #(
	parameter int VB  = 31,
	parameter int IW  = 10,
	parameter int CW  = 11,
	parameter int IDX = 0
) (
	input  logic            clk,
	input  osm_pkg::cmd_t   cmd,
	input  logic [VB-1:0]   v,
	input  logic [CW-1:0]   count,
	input  logic [VB-1:0]   left_value,
	input  osm_pkg::flags_t left_flags,
	input  logic [VB-1:0]   right_value,
	input  osm_pkg::flags_t right_flags,
	output logic [VB-1:0]   value,
	output osm_pkg::flags_t flags,
	output logic [VB+IW:0]  leaf
);
	import osm_pkg::*;

	localparam int CMPW = (VB > CW) ? VB : CW;

	logic [VB-1:0] value_q;
	logic          occupied;
	logic          hit;

	assign value    = value_q;
	assign occupied = CW'(IDX) < count;

	assign flags.lt  = occupied && (value_q < v);
	assign flags.ge  = occupied && (value_q >= v);
	assign flags.gt  = occupied && (value_q > v);
	assign flags.big = !occupied || (value_q > v);

	always_comb begin
		unique case (cmd.op)
			OP_RANK, OP_PRED: hit = flags.lt && !right_flags.lt;
			OP_KTH:           hit = occupied && (CMPW'(v) == CMPW'(IDX + 1));
			OP_SUCC:          hit = flags.gt && !left_flags.gt;
			OP_REMOVE:        hit = flags.ge && !left_flags.ge;
			default:          hit = 1'b0;
		endcase
	end

	// shift right on insert, left on remove
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (cmd.ins && flags.big) begin
				value_q <= left_flags.big ? left_value : v;
			end else if (cmd.rem && flags.ge) begin
				value_q <= right_value;
			end
			leaf <= hit ? {1'b1, IW'(IDX), value_q} : '0;
		end
	end

endmodule

@@ src/osm_tree.sv @@
module osm_tree #(
	parameter int N = 1024,
	parameter int W = 42
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);
	import osm_pkg::*;

	localparam int LEVELS = tree_levels(N);

	logic [W-1:0] lvl [LEVELS+1][N];

	for (genvar k = 0; k < N; k++) begin : g_leaf
		assign lvl[0][k] = leaf[k];
	end

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		localparam int PREV  = level_nodes(N, l - 1);
		localparam int NODES = level_nodes(N, l);
		for (genvar k = 0; k < NODES; k++) begin : g_node
			logic [W-1:0] fold;
			always_comb begin
				fold = '0;
				for (int m = 0; m < TREE_RADIX; m++) begin
					if (k * TREE_RADIX + m < PREV) begin
						fold = fold | lvl[l-1][k * TREE_RADIX + m];
					end
				end
			end
			always_ff @(posedge clk) begin
				lvl[l][k] <= fold;
			end
		end
	end

	assign root = lvl[LEVELS][0];

endmodule

@@ bench/order_statistic_multiset_test.sv @@
module order_statistic_multiset_test;
	timeunit 1ns;
	timeprecision 1ps;

	import osm_pkg::*;

	localparam int CAPACITY   = 1024;
	localparam int VALUE_BITS = 31;

	localparam logic [OP_W-1:0] OP_UNDEF_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_7 = 3'd7;

	localparam logic [OPERAND_W-1:0] TOP_VALUE = '1;

	typedef enum {ARG_RAW, ARG_VALUE, ARG_NEAR, ARG_ORDER} arg_kind_e;

	typedef struct {
		logic [OP_W-1:0]      op;
		arg_kind_e            kind;
		logic [OPERAND_W-1:0] arg;
		int                   delta;
		bit                   drain;
	} plan_t;

	typedef struct packed {
		logic [ANSWER_W-1:0] answer;
		logic [ST_W-1:0]     status;
		logic [ANSWER_W-1:0] running_xor;
	} result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      operation = '0;
	logic [OPERAND_W-1:0] operand = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [ANSWER_W-1:0]  answer;
	logic [ST_W-1:0]      status;
	logic [ANSWER_W-1:0]  running_xor;

	// predictor state
	logic [OPERAND_W-1:0] multiset[$];
	logic [ANSWER_W-1:0]  last_ans = '0;
	logic [ANSWER_W-1:0]  xor_acc = '0;

	plan_t   item_backlog[$];
	result_t answers_due[$];

	int fail_count = 0;
	int send_wait = 0;
	int send_calm = 0;
	int recv_wait = 0;
	int recv_calm = 0;

	order_statistic_multiset #(
		.CAPACITY(CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.operand(operand),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.answer(answer),
		.status(status),
		.running_xor(running_xor)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// index of the first stored value >= v, or > v when strictly_above is set
	function automatic int first_index(logic [OPERAND_W-1:0] v, bit strictly_above);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = multiset.size();
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (strictly_above ? (multiset[mid] <= v) : (multiset[mid] < v)) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	function automatic void apply_to_multiset(logic [OP_W-1:0] op, logic [OPERAND_W-1:0] opnd);
		logic [OPERAND_W-1:0] v;
		result_t r;
		bit hit;
		int pos;
		v = opnd ^ last_ans;
		r.answer = '0;
		r.status = ST_OK;
		hit = 1'b0;
		case (op)
			OP_INSERT: begin
				if (multiset.size() >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					multiset.insert(first_index(v, 1'b1), v);
				end
			end
			OP_REMOVE: begin
				pos = first_index(v, 1'b0);
				if (pos >= multiset.size()) begin
					r.status = ST_NONE;
				end else begin
					multiset.delete(pos);
				end
			end
			OP_RANK: begin
				r.answer = ANSWER_W'(first_index(v, 1'b0) + 1);
				hit = 1'b1;
			end
			OP_KTH: begin
				if (v == 0 || v > multiset.size()) begin
					r.status = ST_NONE;
				end else begin
					r.answer = multiset[v - 1];
					hit = 1'b1;
				end
			end
			OP_PRED: begin
				pos = first_index(v, 1'b0);
				if (pos == 0) begin
					r.status = ST_NONE;
				end else begin
					r.answer = multiset[pos - 1];
					hit = 1'b1;
				end
			end
			OP_SUCC: begin
				pos = first_index(v, 1'b1);
				if (pos >= multiset.size()) begin
					r.status = ST_NONE;
				end else begin
					r.answer = multiset[pos];
					hit = 1'b1;
				end
			end
			default: begin
				r.status = ST_NONE;
			end
		endcase
		if (hit) begin
			last_ans = r.answer;
			xor_acc = xor_acc ^ r.answer;
		end
		r.running_xor = xor_acc;
		answers_due.push_back(r);
	endfunction

	// operands are resolved against the current store when the beat is launched
	function automatic logic [OPERAND_W-1:0] encode_operand(plan_t p);
		logic [OPERAND_W-1:0] x;
		x = p.arg;
		case (p.kind)
			ARG_RAW:
				return p.arg;
			ARG_NEAR: begin
				if (multiset.size() > 0) begin
					x = multiset[$urandom_range(0, multiset.size() - 1)] + p.delta[OPERAND_W-1:0];
				end
			end
			ARG_ORDER:
				x = OPERAND_W'($urandom_range(0, multiset.size() + 1));
			default: ;
		endcase
		return x ^ last_ans;
	endfunction

	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	function automatic void queue_item(logic [OP_W-1:0] op, arg_kind_e kind,
			logic [OPERAND_W-1:0] arg, int delta = 0, bit drain = 1'b0);
		plan_t p;
		p.op = op;
		p.kind = kind;
		p.arg = arg;
		p.delta = delta;
		p.drain = drain;
		item_backlog.push_back(p);
	endfunction

	function automatic void queue_random(logic [OP_W-1:0] op, bit drain = 1'b0);
		int sel;
		sel = $urandom_range(0, 19);
		if (op == OP_KTH && sel < 16) begin
			queue_item(op, ARG_ORDER, '0, 0, drain);
		end else if (sel < 8) begin
			queue_item(op, ARG_VALUE, OPERAND_W'($urandom_range(0, 15)), 0, drain);
		end else if (sel < 13) begin
			queue_item(op, ARG_NEAR, OPERAND_W'($urandom_range(0, 15)),
				$urandom_range(0, 4) - 2, drain);
		end else if (sel < 17) begin
			queue_item(op, ARG_VALUE, OPERAND_W'($urandom), 0, drain);
		end else begin
			case ($urandom_range(0, 3))
				0: queue_item(op, ARG_VALUE, '0, 0, drain);
				1: queue_item(op, ARG_VALUE, OPERAND_W'(1), 0, drain);
				2: queue_item(op, ARG_VALUE, TOP_VALUE - 1, 0, drain);
				default: queue_item(op, ARG_VALUE, TOP_VALUE, 0, drain);
			endcase
		end
	endfunction

	function automatic void queue_mixed(bit drain = 1'b0);
		int r;
		r = $urandom_range(0, 99);
		if (r < 28) begin
			queue_random(OP_INSERT, drain);
		end else if (r < 50) begin
			queue_random(OP_REMOVE, drain);
		end else if (r < 62) begin
			queue_random(OP_RANK, drain);
		end else if (r < 74) begin
			queue_random(OP_KTH, drain);
		end else if (r < 85) begin
			queue_random(OP_PRED, drain);
		end else if (r < 96) begin
			queue_random(OP_SUCC, drain);
		end else if (r < 98) begin
			queue_item($urandom_range(0, 1) ? OP_UNDEF_6 : OP_UNDEF_7, ARG_RAW,
				OPERAND_W'($urandom), 0, drain);
		end else begin
			queue_item(OP_W'($urandom_range(0, 5)), ARG_RAW, OPERAND_W'($urandom), 0, drain);
		end
	endfunction

	// input driver
	always @(posedge clk) begin
		logic busy;
		plan_t nxt;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				apply_to_multiset(operation, operand);
				busy = 1'b0;
				send_wait = draw_wait(send_calm);
			end
			if (!busy) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (item_backlog.size() > 0
						&& !(item_backlog[0].drain && answers_due.size() > 0)) begin
					nxt = item_backlog.pop_front();
					operation <= nxt.op;
					operand <= encode_operand(nxt);
					busy = 1'b1;
				end
			end
			in_valid <= busy;
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$error("result beat with no prediction waiting");
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					if (answer !== want.answer) begin
						$error("answer: expected %0d, got %0d", want.answer, answer);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (running_xor !== want.running_xor) begin
						$error("running_xor: expected %0h, got %0h",
							want.running_xor, running_xor);
						fail_count++;
					end
				end
				recv_wait = draw_wait(recv_calm);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_ready <= (recv_wait == 0);
		end
	end

	initial begin
		int i;

		// empty store
		queue_item(OP_RANK, ARG_VALUE, '0);
		queue_item(OP_KTH, ARG_VALUE, OPERAND_W'(1));
		queue_item(OP_PRED, ARG_VALUE, TOP_VALUE);
		queue_item(OP_SUCC, ARG_VALUE, '0);
		queue_item(OP_REMOVE, ARG_VALUE, '0);
		// extremes and a duplicate pair
		queue_item(OP_INSERT, ARG_VALUE, '0);
		queue_item(OP_INSERT, ARG_VALUE, TOP_VALUE);
		queue_item(OP_INSERT, ARG_VALUE, OPERAND_W'(5));
		queue_item(OP_INSERT, ARG_VALUE, OPERAND_W'(5));
		queue_item(OP_RANK, ARG_VALUE, OPERAND_W'(5));
		queue_item(OP_RANK, ARG_VALUE, TOP_VALUE);
		queue_item(OP_KTH, ARG_VALUE, '0);
		queue_item(OP_KTH, ARG_VALUE, OPERAND_W'(4));
		queue_item(OP_KTH, ARG_VALUE, OPERAND_W'(5));
		queue_item(OP_PRED, ARG_VALUE, '0);
		queue_item(OP_PRED, ARG_VALUE, TOP_VALUE);
		queue_item(OP_SUCC, ARG_VALUE, TOP_VALUE);
		queue_item(OP_SUCC, ARG_VALUE, '0);
		// one copy of a duplicate goes, the other stays
		queue_item(OP_REMOVE, ARG_VALUE, OPERAND_W'(5));
		queue_item(OP_KTH, ARG_VALUE, OPERAND_W'(2));
		// remove takes the next value up, then finds nothing
		queue_item(OP_REMOVE, ARG_VALUE, OPERAND_W'(6));
		queue_item(OP_REMOVE, ARG_VALUE, OPERAND_W'(6));
		queue_item(OP_UNDEF_6, ARG_RAW, TOP_VALUE);
		queue_item(OP_UNDEF_7, ARG_RAW, '0);
		queue_item(OP_INSERT, ARG_RAW, TOP_VALUE);

		// small store, all operations
		queue_mixed(1'b1);
		for (i = 1; i < 120; i++) begin
			queue_mixed();
		end

		// fill to capacity with queries mixed in, then overflow
		queue_random(OP_INSERT, 1'b1);
		for (i = 1; i < CAPACITY + 8; i++) begin
			queue_random(OP_INSERT);
			if (i % 16 == 0) begin
				queue_random(OP_W'($urandom_range(OP_RANK, OP_SUCC)));
			end
		end

		// full store
		queue_item(OP_INSERT, ARG_VALUE, OPERAND_W'($urandom), 0, 1'b1);
		queue_item(OP_REMOVE, ARG_NEAR, '0, 0);
		queue_item(OP_INSERT, ARG_VALUE, TOP_VALUE);
		queue_item(OP_INSERT, ARG_VALUE, '0);
		queue_item(OP_KTH, ARG_VALUE, OPERAND_W'(CAPACITY));
		queue_item(OP_KTH, ARG_VALUE, OPERAND_W'(CAPACITY + 1));
		for (i = 0; i < 40; i++) begin
			queue_mixed();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (item_backlog.size() > 0 || in_valid) begin
			@(posedge clk);
		end
		while (answers_due.size() > 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);

		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
src/osm_pkg.sv
src/osm_cell.sv
src/osm_tree.sv
src/order_statistic_multiset.sv
bench/order_statistic_multiset_test.sv
